// ----- rtl/epc_pkg.sv -----
// Package for the encoder position controller: item types, request codes,
// sequencer states and controller constants. No dependencies.
`timescale 1ns / 1ps

package epc_pkg;

  // Duty range of the PWM timer
  localparam int PWM_TOP = 400;
  localparam int DUTY_W  = 9;

  // Width of the configuration register index and data
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DB_FWD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DB_REV    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FWD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_REV = 3'd6;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_EDGE_A = 2'd0;
  localparam logic [1:0] REQ_EDGE_B = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Largest effort magnitudes after 16-bit signed saturation
  localparam logic [15:0] EFFORT_POS_MAX = 16'h7FFF;
  localparam logic [15:0] EFFORT_NEG_MAX = 16'h8000;

  typedef struct packed {
    logic [1:0] req_type;
    logic       level_a;
    logic       level_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]     position;
    logic [DUTY_W-1:0]      duty;
    logic                   clockwise;
    logic                   at_target;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_ABS,
    S_MUL1,
    S_SAT,
    S_MUL2,
    S_FIN,
    S_SEND
  } state_t;

endpackage

// ----- rtl/encoder_position_p_controller_unit.sv -----
// Encoder position controller top level: quadrature count, proportional law
// and result register. Depends on epc_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_item): one item per encoder edge
//   on A or B, per control tick, or per clear of the count. Each item gives
//   exactly one result on the output channel (out_valid / out_stall /
//   out_item): position, duty, direction and at-target flag after the item.
//   Edge and clear items go straight to the send step, which loads the result
//   register once the output is free. A tick runs error subtract, magnitude and
//   compare, and goes to the send step when the error is within tolerance;
//   otherwise one 16x16 multiplier is used twice (gain times error, then
//   saturated effort times Q16 scale) before the deadband add and clamp.
//   in_stall is high from acceptance until the result is loaded, so no new
//   item is taken before the result of the one before is loaded.
//   The result register is loaded only once the previous result is taken, so
//   a stall on the output holds the result and, after one more item has been
//   worked, stalls the input as well. Configuration writes through cfg_we /
//   cfg_index / cfg_data apply at once and are meant for idle periods.
//   Synchronous reset clears the count, duty, direction and flag and loads
//   the default gain, tolerance, deadband and scale values.
module encoder_position_p_controller_unit
  import epc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic signed [31:0] target_position;
  logic [15:0]        position_tolerance;
  logic [7:0]         proportional_gain;
  logic [8:0]         deadband_forward;
  logic [8:0]         deadband_reverse;
  logic [15:0]        scale_forward_q16;
  logic [15:0]        scale_reverse_q16;

  // Controller state
  logic signed [31:0] encoder_count;
  logic [DUTY_W-1:0]  duty_hold;
  logic               direction_hold;
  logic               settled_flag;

  // Sequencer and working registers
  state_t             state;
  state_t             state_next;
  logic signed [32:0] pos_error;
  logic               err_neg;
  logic [15:0]        err_mag;
  logic [15:0]        eff_mag;
  logic               eff_zero;
  logic [31:0]        prod;

  // Combinational helpers
  logic               in_accept;
  logic               out_accept;
  logic               same_level;
  logic [32:0]        err_abs;
  logic               within_tol;
  logic [15:0]        mul_a;
  logic [15:0]        mul_b;
  logic [31:0]        mul_p;
  logic [15:0]        eff_lim;
  logic [8:0]         db_sel;
  logic [16:0]        duty_sum;
  logic [DUTY_W-1:0]  duty_clamped;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign same_level = (in_item.level_a == in_item.level_b);

  // Error magnitude, tolerance test and clamp to the saturating range
  assign err_abs    = pos_error[32] ? 33'(-pos_error) : 33'(pos_error);
  assign within_tol = (err_abs <= {17'd0, position_tolerance});

  // Shared multiplier: gain times error, then effort times scale
  always_comb begin
    if (state == S_MUL2) begin
      mul_a = eff_mag;
      mul_b = err_neg ? scale_reverse_q16 : scale_forward_q16;
    end else begin
      mul_a = err_mag;
      mul_b = {8'd0, proportional_gain};
    end
  end
  assign mul_p = mul_a * mul_b;

  // Saturation limit and deadband add with clamp
  assign eff_lim  = err_neg ? EFFORT_NEG_MAX : EFFORT_POS_MAX;
  assign db_sel   = err_neg ? deadband_reverse : deadband_forward;
  assign duty_sum = {1'b0, prod[31:16]} + {8'd0, db_sel};
  assign duty_clamped = (duty_sum > 17'(PWM_TOP)) ? DUTY_W'(PWM_TOP) : duty_sum[DUTY_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (in_item.req_type == REQ_TICK) ? S_ERR : S_SEND;
        end
      end
      S_ERR:  state_next = S_ABS;
      S_ABS:  state_next = within_tol ? S_SEND : S_MUL1;
      S_MUL1: state_next = S_SAT;
      S_SAT:  state_next = S_MUL2;
      S_MUL2: state_next = S_FIN;
      S_FIN:  state_next = S_SEND;
      S_SEND: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      target_position    <= 32'sd0;
      position_tolerance <= 16'd5;
      proportional_gain  <= 8'd2;
      deadband_forward   <= 9'd251;
      deadband_reverse   <= 9'd218;
      scale_forward_q16  <= 16'd24445;
      scale_reverse_q16  <= 16'd29819;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET:    target_position    <= $signed(cfg_data);
        REG_TOLERANCE: position_tolerance <= cfg_data[15:0];
        REG_GAIN:      proportional_gain  <= cfg_data[7:0];
        REG_DB_FWD:    deadband_forward   <= cfg_data[8:0];
        REG_DB_REV:    deadband_reverse   <= cfg_data[8:0];
        REG_SCALE_FWD: scale_forward_q16  <= cfg_data[15:0];
        REG_SCALE_REV: scale_reverse_q16  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Count update on accepted edge and clear items
  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_count <= 32'sd0;
    end else if (in_accept) begin
      case (in_item.req_type)
        REQ_EDGE_A: encoder_count <= same_level ? encoder_count - 32'sd1
                                                : encoder_count + 32'sd1;
        REQ_EDGE_B: encoder_count <= same_level ? encoder_count + 32'sd1
                                                : encoder_count - 32'sd1;
        REQ_CLEAR:  encoder_count <= 32'sd0;
        default: ;
      endcase
    end
  end

  // Controller outputs held between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_hold      <= '0;
      direction_hold <= 1'b0;
      settled_flag   <= 1'b0;
    end else begin
      case (state)
        S_ABS: begin
          settled_flag <= within_tol;
          if (within_tol) begin
            duty_hold      <= '0;
            direction_hold <= 1'b0;
          end
        end
        S_FIN: begin
          duty_hold      <= eff_zero ? '0 : duty_clamped;
          direction_hold <= err_neg && !eff_zero && (duty_sum != 17'd0);
        end
        default: ;
      endcase
    end
  end

  // Tick datapath: one step per state
  always_ff @(posedge clk) begin
    case (state)
      S_ERR: begin
        pos_error <= 33'(target_position) - 33'(encoder_count);
      end
      S_ABS: begin
        err_neg <= pos_error[32];
        err_mag <= (err_abs > 33'd32768) ? EFFORT_NEG_MAX : err_abs[15:0];
      end
      S_MUL1: begin
        prod <= mul_p;
      end
      S_SAT: begin
        eff_zero <= (prod == 32'd0);
        eff_mag  <= (prod > {16'd0, eff_lim}) ? eff_lim : prod[15:0];
      end
      S_MUL2: begin
        prod <= mul_p;
      end
      default: ;
    endcase
  end

  // Result register: load once the previous item is gone, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_SEND && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SEND && (!out_valid || !out_stall)) begin
      out_item.position  <= encoder_count;
      out_item.duty      <= duty_hold;
      out_item.clockwise <= direction_hold;
      out_item.at_target <= settled_flag;
    end
  end

endmodule
